/* hw/rtl/msp_pkg.sv */
// Shared types and constants of the matrix saddle point counter.
package msp_pkg;

  // Field and register widths.
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int COUNT_W   = 10;
  localparam int CFG_MAX   = 31;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } msp_reg_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_CMP,
    ST_DRAIN,
    ST_ACC,
    ST_EMIT
  } msp_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic fetch;
    logic compare;
    logic accum;
    logic emit;
  } msp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_last;
    logic cmp_last;
    logic elem_last;
  } msp_status_t;

endpackage

/* hw/rtl/msp_elem_if.sv */
// Input channel carrying one matrix element per item.
interface msp_elem_if;
  logic                               valid;
  logic                               ready;
  logic signed [msp_pkg::DATA_W-1:0]  element_value;

  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

/* hw/rtl/msp_count_if.sv */
// Output channel carrying one saddle count per item.
interface msp_count_if;
  logic                          valid;
  logic                          ready;
  logic [msp_pkg::COUNT_W-1:0]   saddle_count;

  modport source (output valid, output saddle_count, input ready);
  modport sink (input valid, input saddle_count, output ready);
endinterface

/* hw/rtl/msp_ctrl.sv */
// Controller state machine sequencing load, scan and result of the counter.
module msp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  msp_pkg::msp_status_t status_i,
  output msp_pkg::msp_cmd_t    cmd_o
);

  msp_pkg::msp_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  // State and result valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msp_pkg::ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      msp_pkg::ST_LOAD: begin
        // The last element is held off while the previous result still waits.
        in_ready_o = !(status_i.load_last && out_valid_q);
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          if (status_i.load_last) begin
            cmd_o.start = 1'b1;
            state_d     = msp_pkg::ST_FETCH;
          end
        end
      end
      msp_pkg::ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = msp_pkg::ST_CMP;
      end
      msp_pkg::ST_CMP: begin
        cmd_o.compare = 1'b1;
        if (status_i.cmp_last) begin
          state_d = msp_pkg::ST_DRAIN;
        end
      end
      msp_pkg::ST_DRAIN: begin
        state_d = msp_pkg::ST_ACC;
      end
      msp_pkg::ST_ACC: begin
        cmd_o.accum = 1'b1;
        if (status_i.elem_last) begin
          state_d = msp_pkg::ST_EMIT;
        end else begin
          state_d = msp_pkg::ST_FETCH;
        end
      end
      msp_pkg::ST_EMIT: begin
        cmd_o.emit  = 1'b1;
        out_valid_d = 1'b1;
        state_d     = msp_pkg::ST_LOAD;
      end
      default: begin
        state_d = msp_pkg::ST_LOAD;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/msp_datapath.sv */
// Datapath: matrix memory, load and scan counters, compare unit and count.
module msp_datapath #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [msp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [msp_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic signed [msp_pkg::DATA_W-1:0]   element_value_i,
  input  msp_pkg::msp_cmd_t                   cmd_i,
  output msp_pkg::msp_status_t                status_o,
  output logic [msp_pkg::COUNT_W-1:0]         saddle_count_o
);

  localparam int Depth  = MAX_ROWS * MAX_COLS;
  localparam int AW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int RowCap = (MAX_ROWS < msp_pkg::CFG_MAX) ? MAX_ROWS : msp_pkg::CFG_MAX;
  localparam int ColCap = (MAX_COLS < msp_pkg::CFG_MAX) ? MAX_COLS : msp_pkg::CFG_MAX;
  localparam logic [msp_pkg::CFG_W-1:0] RowCapV = RowCap[msp_pkg::CFG_W-1:0];
  localparam logic [msp_pkg::CFG_W-1:0] ColCapV = ColCap[msp_pkg::CFG_W-1:0];
  localparam logic [msp_pkg::CFG_W-1:0] One     = msp_pkg::CFG_W'(1);

  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_V,
    TAG_ROW,
    TAG_COL
  } tag_e;

  logic [msp_pkg::CFG_W-1:0]        row_cfg_q, col_cfg_q;
  logic [msp_pkg::CFG_W-1:0]        rows, cols, rows_m1, cols_m1;
  logic [AW-1:0]                    load_pos_q;
  logic [msp_pkg::CFG_W-1:0]        load_row_q, load_col_q;
  logic [msp_pkg::CFG_W-1:0]        scan_row_q, scan_col_q;
  logic [AW-1:0]                    row_base_q;
  logic [msp_pkg::CFG_W-1:0]        cmp_idx_q;
  logic                             col_phase_q;
  logic [AW-1:0]                    walk_q;
  tag_e                             tag_q, tag_d;
  logic [AW-1:0]                    rd_addr;
  logic signed [msp_pkg::DATA_W-1:0] mem_q [Depth];
  logic signed [msp_pkg::DATA_W-1:0] rdata_q;
  logic signed [msp_pkg::DATA_W-1:0] v_q;
  logic                             hi_q, lo_q;
  logic [msp_pkg::COUNT_W-1:0]      count_q;
  logic [msp_pkg::COUNT_W:0]        count_sum;
  logic [msp_pkg::COUNT_W-1:0]      out_q;

  // Effective sizes: zero counts as one, large values saturate.
  always_comb begin
    if (row_cfg_q == '0) begin
      rows = One;
    end else if (row_cfg_q > RowCapV) begin
      rows = RowCapV;
    end else begin
      rows = row_cfg_q;
    end
    if (col_cfg_q == '0) begin
      cols = One;
    end else if (col_cfg_q > ColCapV) begin
      cols = ColCapV;
    end else begin
      cols = col_cfg_q;
    end
  end

  assign rows_m1 = rows - One;
  assign cols_m1 = cols - One;

  assign status_o.load_last = (load_row_q == rows_m1) && (load_col_q == cols_m1);
  assign status_o.cmp_last  = col_phase_q && (cmp_idx_q == rows_m1);
  assign status_o.elem_last = (scan_row_q == rows_m1) && (scan_col_q == cols_m1);

  // Read address and tag of the word being fetched this cycle.
  always_comb begin
    rd_addr = row_base_q + AW'(scan_col_q);
    tag_d   = TAG_NONE;
    priority if (cmd_i.fetch) begin
      tag_d = TAG_V;
    end else if (cmd_i.compare) begin
      if (!col_phase_q) begin
        rd_addr = row_base_q + AW'(cmp_idx_q);
        tag_d   = (cmp_idx_q == scan_col_q) ? TAG_NONE : TAG_ROW;
      end else begin
        rd_addr = walk_q;
        tag_d   = (cmp_idx_q == scan_row_q) ? TAG_NONE : TAG_COL;
      end
    end else begin
      tag_d = TAG_NONE;
    end
  end

  // Matrix memory: one write port for loading, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem_q[load_pos_q] <= element_value_i;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Element under test and result payload.
  always_ff @(posedge clk_i) begin
    if (tag_q == TAG_V) begin
      v_q <= rdata_q;
    end
    if (cmd_i.emit) begin
      out_q <= count_q;
    end
  end

  assign count_sum = {1'b0, count_q} + (msp_pkg::COUNT_W + 1)'(hi_q)
                     + (msp_pkg::COUNT_W + 1)'(lo_q);

  // Configuration, counters, condition flags and running count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cfg_q   <= msp_pkg::CFG_W'(4);
      col_cfg_q   <= msp_pkg::CFG_W'(4);
      load_pos_q  <= '0;
      load_row_q  <= '0;
      load_col_q  <= '0;
      scan_row_q  <= '0;
      scan_col_q  <= '0;
      row_base_q  <= '0;
      cmp_idx_q   <= '0;
      col_phase_q <= 1'b0;
      walk_q      <= '0;
      tag_q       <= TAG_NONE;
      hi_q        <= 1'b0;
      lo_q        <= 1'b0;
      count_q     <= '0;
    end else begin
      tag_q <= tag_d;

      // A register write discards any partial matrix.
      if (cfg_we_i) begin
        unique case (msp_pkg::msp_reg_e'(cfg_idx_i))
          msp_pkg::REG_ROW_COUNT: row_cfg_q <= cfg_data_i;
          msp_pkg::REG_COL_COUNT: col_cfg_q <= cfg_data_i;
          default: ;
        endcase
        load_pos_q <= '0;
        load_row_q <= '0;
        load_col_q <= '0;
      end else if (cmd_i.load) begin
        if (status_o.load_last) begin
          load_pos_q <= '0;
          load_row_q <= '0;
          load_col_q <= '0;
        end else begin
          load_pos_q <= load_pos_q + AW'(1);
          if (load_col_q == cols_m1) begin
            load_col_q <= '0;
            load_row_q <= load_row_q + One;
          end else begin
            load_col_q <= load_col_q + One;
          end
        end
      end

      // Scan position over all elements.
      if (cmd_i.start) begin
        scan_row_q <= '0;
        scan_col_q <= '0;
        row_base_q <= '0;
      end else if (cmd_i.accum) begin
        if (scan_col_q == cols_m1) begin
          scan_col_q <= '0;
          scan_row_q <= scan_row_q + One;
          row_base_q <= row_base_q + AW'(cols);
        end else begin
          scan_col_q <= scan_col_q + One;
        end
      end

      // Compare index: the row first, then the column.
      if (cmd_i.fetch) begin
        cmp_idx_q   <= '0;
        col_phase_q <= 1'b0;
        walk_q      <= AW'(scan_col_q);
      end else if (cmd_i.compare) begin
        if (!col_phase_q) begin
          if (cmp_idx_q == cols_m1) begin
            cmp_idx_q   <= '0;
            col_phase_q <= 1'b1;
          end else begin
            cmp_idx_q <= cmp_idx_q + One;
          end
        end else begin
          cmp_idx_q <= cmp_idx_q + One;
          walk_q    <= walk_q + AW'(cols);
        end
      end

      // Condition flags, cleared by each strict comparison that fails.
      if (cmd_i.fetch) begin
        hi_q <= 1'b1;
        lo_q <= 1'b1;
      end else if (tag_q == TAG_ROW) begin
        if (v_q <= rdata_q) hi_q <= 1'b0;
        if (v_q >= rdata_q) lo_q <= 1'b0;
      end else if (tag_q == TAG_COL) begin
        if (v_q >= rdata_q) hi_q <= 1'b0;
        if (v_q <= rdata_q) lo_q <= 1'b0;
      end

      // Running count, saturating.
      if (cmd_i.start) begin
        count_q <= '0;
      end else if (cmd_i.accum) begin
        if (count_sum[msp_pkg::COUNT_W]) begin
          count_q <= '1;
        end else begin
          count_q <= count_sum[msp_pkg::COUNT_W-1:0];
        end
      end
    end
  end

  assign saddle_count_o = out_q;

endmodule

/* hw/rtl/matrix_saddle_point_count.sv */
// Top level of the matrix strict saddle point counter.
// Elements of a row_count x col_count matrix arrive in row-major order, one item per
// cycle while loading. After the last element the block scans the stored matrix through
// the single read port of its memory, one word per cycle: for each element it fetches the
// element, reads its row and then its column, and adds the result to the count; the count
// item appears once every element is done. No item is taken during the scan. Loading of
// the next matrix may begin while the count still waits to be taken; only its last element
// is held back until then. Writing row_count or col_count discards a partially loaded
// matrix.
module matrix_saddle_point_count #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  msp_elem_if.sink                        elem_i,
  msp_count_if.source                     count_o,
  input  logic                            cfg_we_i,
  input  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [msp_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int CountMax   = (1 << msp_pkg::COUNT_W) - 1;
  localparam int CountLimit = (2 * MAX_ROWS * MAX_COLS < CountMax) ?
                              2 * MAX_ROWS * MAX_COLS : CountMax;
  localparam logic [msp_pkg::COUNT_W-1:0] CountBound = CountLimit[msp_pkg::COUNT_W-1:0];

  msp_pkg::msp_cmd_t    cmd;
  msp_pkg::msp_status_t status;

  // Sequencing.
  msp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (elem_i.valid),
    .in_ready_o  (elem_i.ready),
    .out_valid_o (count_o.valid),
    .out_ready_i (count_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Storage and arithmetic.
  msp_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .element_value_i (elem_i.element_value),
    .cmd_i           (cmd),
    .status_o        (status),
    .saddle_count_o  (count_o.saddle_count)
  );

`ifndef SYNTHESIS
  // A new result never overwrites one that has not been taken.
  ast_emit_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !count_o.valid)
    else $error("result written while previous result pending");

  // No element is taken while the scan runs.
  ast_no_load_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.fetch || cmd.compare || cmd.accum) |-> !elem_i.ready)
    else $error("input ready during scan");

  // The result is written right after the last accumulation.
  ast_emit_after_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> $past(cmd.accum))
    else $error("result written without preceding accumulation");

  // The count cannot exceed two per memory word, capped at the largest count value.
  ast_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_o.valid |-> (count_o.saddle_count <= CountBound))
    else $error("saddle count out of range");
`endif

endmodule

/* sim/matrix_saddle_point_count_tb.sv */
// Self-checking testbench of the matrix strict saddle point counter.
`timescale 1ns / 100ps

module matrix_saddle_point_count_tb;

  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLS    = 16;
  localparam int ITEM_TARGET = 2000;
  localparam int QUIET_FROM  = 1700;
  localparam int SETTLE      = 8;
  localparam int DRAIN       = 300;
  localparam int CYCLE_LIMIT = 2000000;

  // Ways of filling a matrix with element values.
  typedef enum int {
    FILL_WIDE,
    FILL_TIES,
    FILL_PEAK,
    FILL_VALLEY,
    FILL_FLAT,
    FILL_EXTREME
  } fill_e;

  // Tracks the loaded matrix and holds the saddle counts still to arrive.
  class saddle_tracker;
    logic [msp_pkg::CFG_W-1:0]          row_reg;
    logic [msp_pkg::CFG_W-1:0]          col_reg;
    logic signed [msp_pkg::DATA_W-1:0]  loaded[$];
    logic [msp_pkg::COUNT_W-1:0]        pending_counts[$];
    int                                 mismatches;

    function new();
      row_reg    = 5'd4;
      col_reg    = 5'd4;
      mismatches = 0;
    endfunction

    function int eff_rows();
      if (row_reg == 0) return 1;
      if (row_reg > MAX_ROWS) return MAX_ROWS;
      return int'(row_reg);
    endfunction

    function int eff_cols();
      if (col_reg == 0) return 1;
      if (col_reg > MAX_COLS) return MAX_COLS;
      return int'(col_reg);
    endfunction

    // A register write also drops any partially loaded matrix.
    function void set_register(msp_pkg::msp_reg_e idx, logic [msp_pkg::CFG_W-1:0] val);
      if (idx == msp_pkg::REG_ROW_COUNT) row_reg = val;
      else col_reg = val;
      loaded.delete();
    endfunction

    // Both strict saddle conditions, summed over every element.
    function logic [msp_pkg::COUNT_W-1:0] count_saddles();
      int rows;
      int cols;
      int total;
      bit hi_row_lo_col;
      bit lo_row_hi_col;
      logic signed [msp_pkg::DATA_W-1:0] v;
      logic signed [msp_pkg::DATA_W-1:0] w;
      rows  = eff_rows();
      cols  = eff_cols();
      total = 0;
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < cols; c++) begin
          v = loaded[r*cols+c];
          hi_row_lo_col = 1'b1;
          lo_row_hi_col = 1'b1;
          for (int k = 0; k < cols; k++) begin
            if (k != c) begin
              w = loaded[r*cols+k];
              if (v <= w) hi_row_lo_col = 1'b0;
              if (v >= w) lo_row_hi_col = 1'b0;
            end
          end
          for (int k = 0; k < rows; k++) begin
            if (k != r) begin
              w = loaded[k*cols+c];
              if (v >= w) hi_row_lo_col = 1'b0;
              if (v <= w) lo_row_hi_col = 1'b0;
            end
          end
          total += int'(hi_row_lo_col) + int'(lo_row_hi_col);
          if (total > 1023) total = 1023;
        end
      end
      return total[msp_pkg::COUNT_W-1:0];
    endfunction

    // An accepted element; the last one of a matrix yields one count.
    function void note_element(logic signed [msp_pkg::DATA_W-1:0] v);
      loaded.push_back(v);
      if (loaded.size() >= eff_rows() * eff_cols()) begin
        pending_counts.push_back(count_saddles());
        loaded.delete();
      end
    endfunction

    // An accepted count item against the oldest pending count.
    function void check_count(logic [msp_pkg::COUNT_W-1:0] got);
      logic [msp_pkg::COUNT_W-1:0] want;
      if (pending_counts.size() == 0) begin
        $display("%0t: saddle_count expected none, actual %0d", $time, got);
        mismatches++;
      end else begin
        want = pending_counts.pop_front();
        if (got !== want) begin
          $display("%0t: saddle_count expected %0d, actual %0d", $time, want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we_i;
  msp_pkg::msp_reg_e           cfg_idx_i;
  logic [msp_pkg::CFG_W-1:0]   cfg_data_i;

  msp_elem_if  elem_ch();
  msp_count_if count_ch();

  saddle_tracker tracker = new();

  int items_sent;
  int cycle_count = 0;
  int stall_left = 0;
  bit quiet;

  matrix_saddle_point_count #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .elem_i     (elem_ch),
    .count_o    (count_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run limit: a hung block ends the run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver with random stall bursts, steady in the last part of the run.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      count_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      count_ch.ready <= 1'b0;
    end else begin
      count_ch.ready <= 1'b1;
    end
  end

  // Every accepted count item is checked.
  always @(posedge clk_i) begin
    if (rst_ni && count_ch.valid && count_ch.ready) begin
      tracker.check_count(count_ch.saddle_count);
    end
  end

  // Offer one element, with an optional idle burst ahead of it.
  task automatic send_element(logic signed [msp_pkg::DATA_W-1:0] v);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      elem_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    elem_ch.valid         <= 1'b1;
    elem_ch.element_value <= v;
    do @(posedge clk_i); while (!(elem_ch.valid && elem_ch.ready));
    tracker.note_element(v);
    items_sent++;
    quiet = (items_sent >= QUIET_FROM);
  endtask

  // Stop offering and wait until every pending count has come.
  task automatic wait_idle();
    elem_ch.valid <= 1'b0;
    while (tracker.pending_counts.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write the row size register and then the column size register.
  task automatic write_config(logic [msp_pkg::CFG_W-1:0] rows,
                              logic [msp_pkg::CFG_W-1:0] cols);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= msp_pkg::REG_ROW_COUNT;
    cfg_data_i <= rows;
    @(posedge clk_i);
    tracker.set_register(msp_pkg::REG_ROW_COUNT, rows);
    cfg_idx_i  <= msp_pkg::REG_COL_COUNT;
    cfg_data_i <= cols;
    @(posedge clk_i);
    tracker.set_register(msp_pkg::REG_COL_COUNT, cols);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic signed [msp_pkg::DATA_W-1:0] wide_value();
    return $urandom;
  endfunction

  function automatic logic signed [msp_pkg::DATA_W-1:0] extreme_value();
    case ($urandom_range(0, 3))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  // Sizes lean small; zero and oversized values are rare.
  function automatic logic [msp_pkg::CFG_W-1:0] pick_size();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return msp_pkg::CFG_W'($urandom_range(1, 4));
    if (pick < 18) return msp_pkg::CFG_W'($urandom_range(5, 16));
    if (pick == 18) return 5'd0;
    return msp_pkg::CFG_W'($urandom_range(17, 31));
  endfunction

  // Build one full matrix of the current size and send it.
  task automatic send_matrix(fill_e fill);
    logic signed [msp_pkg::DATA_W-1:0] vals [0:MAX_ROWS*MAX_COLS-1];
    int rows;
    int cols;
    int r0;
    int c0;
    int center;
    logic signed [msp_pkg::DATA_W-1:0] flat;
    rows   = tracker.eff_rows();
    cols   = tracker.eff_cols();
    r0     = $urandom_range(0, rows - 1);
    c0     = $urandom_range(0, cols - 1);
    center = int'($urandom_range(0, 2000000000)) - 1000000000;
    flat   = wide_value();
    for (int i = 0; i < rows * cols; i++) begin
      case (fill)
        FILL_TIES:    vals[i] = int'($urandom_range(0, 6)) - 3;
        FILL_FLAT:    vals[i] = flat;
        FILL_EXTREME: vals[i] = extreme_value();
        default:      vals[i] = wide_value();
      endcase
    end
    // Plant one strict saddle element; row and column cells are disjoint.
    if (fill == FILL_PEAK || fill == FILL_VALLEY) begin
      for (int k = 0; k < cols; k++) begin
        if (fill == FILL_PEAK) vals[r0*cols+k] = center - int'($urandom_range(1, 1000));
        else vals[r0*cols+k] = center + int'($urandom_range(1, 1000));
      end
      for (int k = 0; k < rows; k++) begin
        if (fill == FILL_PEAK) vals[k*cols+c0] = center + int'($urandom_range(1, 1000));
        else vals[k*cols+c0] = center - int'($urandom_range(1, 1000));
      end
      vals[r0*cols+c0] = center;
    end
    for (int i = 0; i < rows * cols; i++) send_element(vals[i]);
  endtask

  // Reset, directed cases, then random phases.
  initial begin
    int   total;
    int   matrices;
    int   phase;
    int   pick;
    fill_e fill;
    logic [msp_pkg::CFG_W-1:0] rows;
    logic [msp_pkg::CFG_W-1:0] cols;

    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = msp_pkg::REG_ROW_COUNT;
    cfg_data_i            = '0;
    elem_ch.valid         = 1'b0;
    elem_ch.element_value = '0;
    items_sent            = 0;
    quiet                 = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero sizes act as a 1x1 matrix; each single element counts both conditions.
    write_config(5'd0, 5'd0);
    send_element(32'sh7FFF_FFFF);
    send_element(32'sh8000_0000);
    wait_idle();

    // A 2x2 matrix with one element of each saddle kind, then an all-equal one.
    write_config(5'd2, 5'd2);
    send_element(32'sd0);
    send_element(32'sh8000_0000);
    send_element(32'sh7FFF_FFFF);
    send_element(-32'sd1);
    send_matrix(FILL_FLAT);

    // A partial matrix dropped by a size write, then a fresh 1x2 matrix.
    send_element(32'sd5);
    send_element(-32'sd5);
    send_element(32'sd7);
    wait_idle();
    write_config(5'd1, 5'd2);
    send_element(32'sh5555_5555);
    send_element(32'shAAAA_AAAA);

    // Random phases: sizes change only once every pending count has come.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      total = tracker.eff_rows() * tracker.eff_cols();
      // Now and then leave a matrix half loaded before the next size write.
      if (total > 1 && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, total - 1)) send_element(wide_value());
        wait_idle();
      end
      case (phase)
        0: begin rows = 5'd31; cols = 5'd1; end
        1: begin rows = 5'd1;  cols = 5'd31; end
        2: begin rows = 5'd16; cols = 5'd16; end
        default: begin rows = pick_size(); cols = pick_size(); end
      endcase
      write_config(rows, cols);
      phase++;
      total    = tracker.eff_rows() * tracker.eff_cols();
      matrices = $urandom_range(1, (60 / total > 1) ? 60 / total : 1);
      for (int m = 0; m < matrices; m++) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) fill = FILL_WIDE;
        else if (pick < 4) fill = FILL_TIES;
        else if (pick < 6) fill = FILL_PEAK;
        else if (pick < 8) fill = FILL_VALLEY;
        else if (pick == 8) fill = FILL_FLAT;
        else fill = FILL_EXTREME;
        send_matrix(fill);
      end
    end

    // Drain, then give any stray count item time to show up.
    wait_idle();
    repeat (DRAIN) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_counts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/msp_pkg.sv
hw/rtl/msp_elem_if.sv
hw/rtl/msp_count_if.sv
hw/rtl/msp_ctrl.sv
hw/rtl/msp_datapath.sv
hw/rtl/matrix_saddle_point_count.sv
sim/matrix_saddle_point_count_tb.sv
